/* design/exfat_pkg.sv */
// shared types, codes and constants for the exfat cluster chain reader
package exfat_pkg;

    localparam int SHIFT_W    = 5;
    localparam int SHIFT_MAX  = 25;
    localparam int LEN_W      = SHIFT_MAX + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] ACT_OPEN   = 2'd0;
    localparam logic [1:0] ACT_RAW    = 2'd1;
    localparam logic [1:0] ACT_REFILL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_START     = 2'd2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_CHAIN   = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_MEDIA   = 3'd4;
    localparam logic [2:0] ST_CORRUPT = 3'd5;

    localparam logic [31:0] FAT_LAST_LINK = 32'hfffffff6;
    localparam logic [31:0] FAT_BAD       = 32'hfffffff7;
    localparam logic [31:0] FAT_MEDIA     = 32'hfffffff8;
    localparam logic [31:0] FAT_EOC       = 32'hffffffff;
    localparam logic [31:0] FAT_FIRST     = 32'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] head_cluster;
        logic [63:0] valid_length;
        logic [63:0] file_length;
        logic        contiguous;
        logic [31:0] fat_word;
    } req_t;

    typedef struct packed {
        logic [63:0]      data_offset;
        logic [LEN_W-1:0] read_length;
        logic [LEN_W-1:0] zero_length;
        logic [63:0]      entry_offset;
        logic [2:0]       status;
    } rsp_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [31:0]        reserved_clusters;
        logic [31:0]        fat_start_cluster;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cluster;
        logic [63:0] file_left;
        logic [63:0] valid_left;
        logic        linear_run;
    } chain_state_t;

endpackage

/* design/exfat_cfg.sv */
// configuration registers with the clipped cluster shift
module exfat_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [exfat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [exfat_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output exfat_pkg::cfg_t                    cfg
);
    import exfat_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;
    logic [31:0]        reserved_reg;
    logic [31:0]        fat_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= SHIFT_RESET;
            reserved_reg  <= '0;
            fat_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLUSTER_SHIFT: shift_reg     <= cfg_wdata[SHIFT_W-1:0];
                CFG_RESERVED:      reserved_reg  <= cfg_wdata;
                CFG_FAT_START:     fat_start_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.shift             = (shift_reg > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX)
                                                                  : shift_reg;
        cfg.reserved_clusters = reserved_reg;
        cfg.fat_start_cluster = fat_start_reg;
    end

endmodule

/* design/exfat_step.sv */
// next chain state and result for one transaction
module exfat_step (
    input  exfat_pkg::req_t          req,
    input  exfat_pkg::chain_state_t  cur,
    input  exfat_pkg::cfg_t          cfg,
    output exfat_pkg::chain_state_t  nxt,
    output exfat_pkg::rsp_t          rsp,
    output logic                     has_rsp
);
    import exfat_pkg::*;

    logic [LEN_W-1:0] csize;
    logic [LEN_W-1:0] block;
    logic [LEN_W-1:0] readable;
    logic [31:0]      rel;
    logic [63:0]      fat_base;

    always_comb
    begin
        csize    = LEN_W'(1) << cfg.shift;
        block    = (cur.file_left < {{(64-LEN_W){1'b0}}, csize}) ? cur.file_left[LEN_W-1:0]
                                                                 : csize;
        readable = (cur.valid_left < {{(64-LEN_W){1'b0}}, block}) ? cur.valid_left[LEN_W-1:0]
                                                                  : block;
        rel      = cur.cluster + cfg.reserved_clusters - FAT_FIRST;
        fat_base = {32'd0, cfg.fat_start_cluster} << cfg.shift;

        nxt             = cur;
        has_rsp         = 1'b1;
        rsp.data_offset = '0;
        rsp.read_length = '0;
        rsp.zero_length = '0;
        rsp.status      = ST_OK;

        case (req.action)
            ACT_OPEN:
            begin
                nxt.file_left  = req.file_length;
                nxt.valid_left = (req.valid_length > req.file_length) ? req.file_length
                                                                      : req.valid_length;
                nxt.cluster    = req.head_cluster;
                nxt.linear_run = req.contiguous;
            end
            ACT_RAW:
            begin
                nxt.file_left  = '1;
                nxt.valid_left = '1;
                nxt.cluster    = req.head_cluster;
                nxt.linear_run = 1'b1;
            end
            ACT_REFILL:
            begin
                if (cur.cluster == '0 || cur.file_left == '0)
                begin
                    rsp.status = ST_END;
                end
                else if (cur.valid_left == '0)
                begin
                    nxt.file_left   = cur.file_left - {{(64-LEN_W){1'b0}}, block};
                    rsp.zero_length = block;
                end
                else
                begin
                    rsp.data_offset = {32'd0, rel} << cfg.shift;
                    if (cur.linear_run)
                    begin
                        nxt.cluster = cur.cluster + 32'd1;
                    end
                    else if (req.fat_word > FAT_LAST_LINK || req.fat_word < FAT_FIRST)
                    begin
                        nxt.cluster = '0;
                        if (req.fat_word == FAT_BAD)
                            rsp.status = ST_BAD;
                        else if (req.fat_word == FAT_MEDIA)
                            rsp.status = ST_MEDIA;
                        else if (req.fat_word == FAT_EOC)
                            rsp.status = ST_CHAIN;
                        else
                            rsp.status = ST_CORRUPT;
                    end
                    else
                    begin
                        nxt.cluster = req.fat_word;
                    end
                    nxt.file_left   = cur.file_left - {{(64-LEN_W){1'b0}}, block};
                    nxt.valid_left  = cur.valid_left - {{(64-LEN_W){1'b0}}, readable};
                    rsp.read_length = readable;
                    rsp.zero_length = block - readable;
                end
            end
            default:
            begin
                has_rsp = 1'b0;
            end
        endcase

        rsp.entry_offset = fat_base + {30'd0, nxt.cluster, 2'b00};
    end

endmodule

/* design/exfat_cluster_chain_reader.sv */
// an accepted transaction is held in the input register, its result is then registered in the result register
// throughput: one transaction per cycle while no held result stalls it, the chain state loops through one step stage
// an input register and a result register part the channels, a held result stops
// input only once the input register also holds a transaction
// reset: asynchronous active low, clears chain state and valids, cluster shift to 12
module exfat_cluster_chain_reader (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  exfat_pkg::req_t                    req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output exfat_pkg::rsp_t                    rsp,
    input  logic                               cfg_we,
    input  logic [exfat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [exfat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import exfat_pkg::*;

    cfg_t         cfg;
    req_t         req_reg;
    logic         req_vld_reg;
    rsp_t         rsp_reg;
    logic         rsp_vld_reg;
    chain_state_t state_reg;
    chain_state_t state_next;
    rsp_t         rsp_next;
    logic         has_rsp;
    logic         advance;
    logic         accept;

    exfat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    exfat_step u_step (
        .req     (req_reg),
        .cur     (state_reg),
        .cfg     (cfg),
        .nxt     (state_next),
        .rsp     (rsp_next),
        .has_rsp (has_rsp)
    );

    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            if (accept)
                req_vld_reg <= 1'b1;
            else if (advance)
                req_vld_reg <= 1'b0;

            if (advance && has_rsp)
                rsp_vld_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_vld_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        if (advance && has_rsp)
            rsp_reg <= rsp_next;
    end

endmodule

/* design/exfat_checker.sv */
// port level checks for the exfat cluster chain reader
module exfat_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_stall,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  exfat_pkg::rsp_t   rsp
);
    import exfat_pkg::*;

    // a held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // with the result register empty the block always takes a transaction
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("stall with empty result register");

    // one block never exceeds the largest cluster
    a_block_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp.read_length} + {1'b0, rsp.zero_length})
                      <= (LEN_W + 1)'(1 << SHIFT_MAX))
        else $error("block larger than a cluster");

    // end of data plans nothing
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_END |->
            rsp.data_offset == '0 && rsp.read_length == '0 && rsp.zero_length == '0)
        else $error("end of data with a planned block");

endmodule

bind exfat_cluster_chain_reader exfat_checker u_exfat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
